### sv/bandwidth_percent_converter_assert.svh
// Assertion macros for the bandwidth percent converter.
// No dependencies; included by the RTL files that carry assertions.
`ifndef BANDWIDTH_PERCENT_CONVERTER_ASSERT_SVH
`define BANDWIDTH_PERCENT_CONVERTER_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

// next-cycle implication
`define BPC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpc assertion failed");

`endif

### sv/bpc_pkg.sv
// Shared types, constants and helper functions for the bandwidth percent converter.
// No dependencies.
package bpc_pkg;

  localparam int unsigned FULL_PERCENT       = 100;
  localparam int unsigned MILLI_SCALE        = 1000;
  localparam int unsigned FRACTION_WORD_BITS = 16;
  localparam int unsigned CELLS              = FRACTION_WORD_BITS;
  localparam logic [5:0]  BITMAP_MAX_BITS    = 6'd32;
  localparam logic [4:0]  FRACTION_MAX_BITS  = 5'(FRACTION_WORD_BITS);

  localparam logic [1:0] REG_FORMAT_MODE   = 2'd0;
  localparam logic [1:0] REG_FRACTION_BITS = 2'd1;
  localparam logic [1:0] REG_BITMAP_BITS   = 2'd2;

  typedef enum logic [1:0] {
    KIND_FENC,   // percent to max fraction word
    KIND_FDEC,   // max fraction word to percent
    KIND_DIV,    // bitmap to percent, quotient is the result
    KIND_DIVM    // percent to bitmap, quotient is the run length
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  divisor;
    logic [16:0] acc;
    logic [15:0] bits;
    logic        flag;
  } cell_data_t;

  function automatic logic [31:0] low_mask(logic [5:0] n);
    logic [31:0] m;
    if (n >= 6'd32) m = '1;
    else m = (32'd1 << n[4:0]) - 32'd1;
    return m;
  endfunction

  // milli-percent weight of fraction bit (15 - idx)
  function automatic logic [16:0] enc_weight(logic [3:0] idx);
    logic [4:0] sh;
    sh = {1'b0, idx} + 5'd1;
    return 17'(FULL_PERCENT * MILLI_SCALE) >> sh;
  endfunction

  // truncated percent weight of fraction bit (15 - idx)
  function automatic logic [6:0] dec_weight(logic [3:0] idx);
    logic [4:0] sh;
    sh = {1'b0, idx} + 5'd1;
    return 7'(FULL_PERCENT) >> sh;
  endfunction

endpackage

### sv/bpc_front.sv
// Input stages: clamping, popcount, run product, and cell chain setup.
// Depends on bpc_pkg.
module bpc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                operation,
  input  logic [7:0]          percent_in,
  input  logic [31:0]         control_in,
  input  logic                format_mode,
  input  logic [5:0]          bitmap_width,
  input  logic                next_ready,
  output logic                ready,
  output logic                valid,
  output bpc_pkg::cell_data_t data
);

  typedef struct packed {
    bpc_pkg::kind_t kind;
    logic [6:0]     divisor;
    logic [11:0]    num;
    logic [15:0]    ctl;
  } front_t;

  logic       va;
  front_t     sa;
  front_t     sa_next;
  logic       ready_b;
  logic [6:0] pc;
  logic [31:0] masked;
  logic [1:0] p1 [16];
  logic [2:0] p2 [8];
  logic [3:0] p3 [4];
  logic [4:0] p4 [2];
  logic [5:0] cnt;
  bpc_pkg::cell_data_t sb_next;

  assign ready_b = !valid || next_ready;
  assign ready   = !va || ready_b;

  always_comb begin
    pc = (percent_in > 8'(bpc_pkg::FULL_PERCENT)) ? 7'(bpc_pkg::FULL_PERCENT) : percent_in[6:0];
    masked = control_in & bpc_pkg::low_mask(bitmap_width);
    for (int i = 0; i < 16; i++) p1[i] = {1'b0, masked[2*i]} + {1'b0, masked[2*i+1]};
    for (int i = 0; i < 8; i++)  p2[i] = {1'b0, p1[2*i]} + {1'b0, p1[2*i+1]};
    for (int i = 0; i < 4; i++)  p3[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
    for (int i = 0; i < 2; i++)  p4[i] = {1'b0, p3[2*i]} + {1'b0, p3[2*i+1]};
    cnt = {1'b0, p4[0]} + {1'b0, p4[1]};

    sa_next.ctl     = control_in[15:0];
    sa_next.divisor = 7'(bpc_pkg::FULL_PERCENT);
    sa_next.num     = '0;
    if (!format_mode) begin
      if (!operation) begin
        sa_next.kind = bpc_pkg::KIND_DIVM;
        sa_next.num  = 12'(pc) * 12'(bitmap_width);
      end else if (bitmap_width == 6'd0) begin
        sa_next.kind = bpc_pkg::KIND_DIVM;
      end else begin
        sa_next.kind    = bpc_pkg::KIND_DIV;
        sa_next.num     = 12'(cnt);
        sa_next.divisor = 7'(bitmap_width);
      end
    end else if (!operation) begin
      sa_next.kind = bpc_pkg::KIND_FENC;
      sa_next.num  = 12'(pc);
    end else begin
      sa_next.kind = bpc_pkg::KIND_FDEC;
    end
  end

  always_comb begin
    sb_next.kind    = sa.kind;
    sb_next.divisor = sa.divisor;
    sb_next.acc     = '0;
    sb_next.bits    = '0;
    sb_next.flag    = 1'b1;
    case (sa.kind)
      bpc_pkg::KIND_FENC: sb_next.acc  = 17'(sa.num) * 17'(bpc_pkg::MILLI_SCALE);
      bpc_pkg::KIND_FDEC: sb_next.bits = sa.ctl;
      bpc_pkg::KIND_DIV:  sb_next.bits = 16'(sa.num) * 16'(bpc_pkg::FULL_PERCENT);
      default:            sb_next.bits = 16'(sa.num);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (ready)   va    <= item_valid;
      if (ready_b) valid <= va;
    end
    if (ready && item_valid) sa   <= sa_next;
    if (ready_b && va)       data <= sb_next;
  end

endmodule

### sv/bpc_cell.sv
// One step cell: greedy fraction bit, weight sum, or restoring division bit.
// Depends on bpc_pkg.
module bpc_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          step_idx,
  input  logic [4:0]          frac_width,
  input  logic                prev_valid,
  input  bpc_pkg::cell_data_t prev_data,
  input  logic                next_ready,
  output logic                ready,
  output logic                valid,
  output bpc_pkg::cell_data_t data
);

  logic        active;
  logic        msb;
  logic        ge;
  logic [16:0] enc_w;
  logic [6:0]  dec_w;
  logic [7:0]  rem;
  logic [7:0]  rem_sub;
  bpc_pkg::cell_data_t data_next;

  assign ready = !valid || next_ready;

  always_comb begin
    active    = {1'b0, step_idx} < frac_width;
    msb       = prev_data.bits[15];
    enc_w     = bpc_pkg::enc_weight(step_idx);
    dec_w     = bpc_pkg::dec_weight(step_idx);
    rem       = {prev_data.acc[6:0], msb};
    rem_sub   = rem - {1'b0, prev_data.divisor};
    ge        = 1'b0;
    data_next = prev_data;
    case (prev_data.kind)
      bpc_pkg::KIND_FENC: begin
        ge = active && (prev_data.acc >= enc_w);
        if (ge) data_next.acc = prev_data.acc - enc_w;
        data_next.bits = {prev_data.bits[14:0], ge};
      end
      bpc_pkg::KIND_FDEC: begin
        if (active && msb) data_next.acc = prev_data.acc + 17'(dec_w);
        data_next.flag = prev_data.flag && (!active || msb);
        data_next.bits = {prev_data.bits[14:0], 1'b0};
      end
      default: begin
        ge = rem >= {1'b0, prev_data.divisor};
        data_next.acc  = 17'(ge ? rem_sub[6:0] : rem[6:0]);
        data_next.bits = {prev_data.bits[14:0], ge};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= prev_valid;
    end
    if (ready && prev_valid) data <= data_next;
  end

endmodule

### sv/bpc_output.sv
// Output register: forms the result word from the last cell's data.
// Depends on bpc_pkg.
module bpc_output (
  input  logic                clk,
  input  logic                rst,
  input  logic                prev_valid,
  input  bpc_pkg::cell_data_t prev_data,
  input  logic                result_stall,
  output logic                ready,
  output logic                result_valid,
  output logic [31:0]         converted_value
);

  logic [31:0] value_next;

  assign ready = !result_valid || !result_stall;

  always_comb begin
    case (prev_data.kind)
      bpc_pkg::KIND_FDEC:
        value_next = prev_data.flag ? 32'(bpc_pkg::FULL_PERCENT) : 32'(prev_data.acc);
      bpc_pkg::KIND_DIVM:
        value_next = bpc_pkg::low_mask(prev_data.bits[5:0]);
      default:
        value_next = 32'(prev_data.bits);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= prev_valid;
    end
    if (ready && prev_valid) converted_value <= value_next;
  end

endmodule

### sv/bandwidth_percent_converter.sv
// An accepted item beat passes two setup stages, a chain of 16 step cells and
// one output register. Throughput: one beat per cycle while result_stall is low;
// each cell does one fraction or quotient bit. Stalled beats collapse bubbles,
// so upstream cells keep filling behind a stall.
// Reset clears all valid flags and loads format_mode 0, fraction_bits 16,
// bitmap_bits 32; cfg_ready is always high.
`include "bandwidth_percent_converter_assert.svh"

module bandwidth_percent_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        operation,
  input  logic [7:0]  percent_in,
  input  logic [31:0] control_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] converted_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int unsigned LAST = bpc_pkg::CELLS - 1;

  logic       format_mode;
  logic [4:0] fraction_bits;
  logic [5:0] bitmap_bits;
  logic [4:0] frac_width;
  logic [5:0] bitmap_width;

  logic                front_ready;
  logic                front_valid;
  bpc_pkg::cell_data_t front_data;
  logic                cv [bpc_pkg::CELLS];
  logic                cr [bpc_pkg::CELLS];
  bpc_pkg::cell_data_t cd [bpc_pkg::CELLS];
  logic                out_ready;

  assign cfg_ready  = 1'b1;
  assign item_stall = !front_ready;
  assign frac_width = (fraction_bits > bpc_pkg::FRACTION_MAX_BITS) ?
                      bpc_pkg::FRACTION_MAX_BITS : fraction_bits;
  assign bitmap_width = (bitmap_bits > bpc_pkg::BITMAP_MAX_BITS) ?
                        bpc_pkg::BITMAP_MAX_BITS : bitmap_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode   <= 1'b0;
      fraction_bits <= 5'd16;
      bitmap_bits   <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpc_pkg::REG_FORMAT_MODE:   format_mode   <= cfg_data[0];
        bpc_pkg::REG_FRACTION_BITS: fraction_bits <= cfg_data[4:0];
        bpc_pkg::REG_BITMAP_BITS:   bitmap_bits   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .operation    (operation),
    .percent_in   (percent_in),
    .control_in   (control_in),
    .format_mode  (format_mode),
    .bitmap_width (bitmap_width),
    .next_ready   (cr[0]),
    .ready        (front_ready),
    .valid        (front_valid),
    .data         (front_data)
  );

  for (genvar i = 0; i < bpc_pkg::CELLS; i++) begin : g_cell
    logic                pv;
    logic                nr;
    bpc_pkg::cell_data_t pd;
    if (i == 0) begin : g_first
      assign pv = front_valid;
      assign pd = front_data;
    end else begin : g_mid
      assign pv = cv[i-1];
      assign pd = cd[i-1];
    end
    if (i == LAST) begin : g_last
      assign nr = out_ready;
    end else begin : g_next
      assign nr = cr[i+1];
    end
    bpc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .step_idx   (4'(i)),
      .frac_width (frac_width),
      .prev_valid (pv),
      .prev_data  (pd),
      .next_ready (nr),
      .ready      (cr[i]),
      .valid      (cv[i]),
      .data       (cd[i])
    );
  end

  bpc_output u_output (
    .clk             (clk),
    .rst             (rst),
    .prev_valid      (cv[LAST]),
    .prev_data       (cd[LAST]),
    .result_stall    (result_stall),
    .ready           (out_ready),
    .result_valid    (result_valid),
    .converted_value (converted_value)
  );

  `BPC_ASSERT_IMP(a_empty_out_takes_item, clk, rst, !result_valid, !item_stall)
  `BPC_ASSERT_NXT(a_last_cell_holds, clk, rst, cv[LAST] && !out_ready, cv[LAST] && $stable(cd[LAST]))
  `BPC_ASSERT_NXT(a_out_drains, clk, rst, result_valid && !result_stall && !cv[LAST], !result_valid)

endmodule
